FILE: sv/sebe_pkg.sv
// Shared types, constants and helpers for the song event byte encoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package sebe_pkg;

  localparam int TIME_BITS       = 24;
  localparam int MAX_LONG_DELAYS = 59;

  localparam int LONG_STEP_SH = 13;
  localparam int LONG_W       = $clog2(MAX_LONG_DELAYS + 1);
  localparam int LIM_W        = 34;
  localparam int REM_W        = LONG_STEP_SH + 1;
  localparam logic [LIM_W-1:0] LONG_LIMIT =
    LIM_W'((MAX_LONG_DELAYS + 1) * (1 << LONG_STEP_SH));
  localparam logic [REM_W-1:0] COARSE_MIN = REM_W'(128);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [6:0] NOTE_BASE_RESET = 7'd39;
  localparam logic [7:0] LONG_BYTE       = 8'hbf;
  localparam logic [7:0] COARSE_TAG      = 8'h80;
  localparam logic [1:0] NOTE_TAG        = 2'b11;
  localparam logic [5:0] NOTE_SPAN       = 6'h3f;
  localparam logic [5:0] DUR_MAX         = 6'h3f;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BACKWARD = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_CHANNEL  = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;

  typedef struct packed {
    logic              err;
    logic [2:0]        status;
    logic [LONG_W-1:0] n_long;
    logic              has_coarse;
    logic [7:0]        coarse_byte;
    logic              has_fine;
    logic [7:0]        fine_byte;
    logic              has_note0;
    logic [7:0]        note0_byte;
    logic              has_note1;
    logic [7:0]        note1_byte;
  } sebe_item_t;

  function automatic logic item_pending(sebe_item_t it);
    return it.err | (it.n_long != '0) | it.has_coarse | it.has_fine |
           it.has_note0 | it.has_note1;
  endfunction

endpackage

FILE: sv/sebe_front.sv
// Front end: accepts input transactions, runs the error checks and splits the delay.
// Holds the write head and the note base register; depends on sebe_pkg.
module sebe_front import sebe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_command,
  input  logic [23:0]      in_event_time,
  input  logic [6:0]       in_note_number,
  input  logic [3:0]       in_channel,
  input  logic [15:0]      in_duration,
  input  logic             cfg_valid,
  input  logic [6:0]       cfg_note_base,
  input  logic             q_full,
  output logic             push,
  output sebe_item_t       push_item
);

  logic [TIME_BITS-1:0] wh_r, wh_nxt;
  logic [6:0]           base_r, base_nxt;

  logic [TIME_BITS-1:0] t;
  logic [TIME_BITS-1:0] d;
  logic [LIM_W-1:0]     d_ext;
  logic [LIM_W-1:0]     dm1;
  logic [REM_W-1:0]     rem;
  logic [7:0]           fine_val;
  logic [7:0]           base_top;
  logic [11:0]          dur_q;
  logic [5:0]           dur_sat;
  logic                 d_nz;
  logic                 range_bad;
  logic                 ch_bad;
  logic                 accept;
  logic [2:0]           status;
  sebe_item_t           item;

  always_comb begin
    t         = TIME_BITS'(in_event_time);
    d         = t - wh_r;
    d_ext     = LIM_W'(d);
    d_nz      = (d != '0);
    dm1       = d_ext - LIM_W'(1);
    rem       = REM_W'(dm1[LONG_STEP_SH-1:0]) + REM_W'(1);
    base_top  = {1'b0, base_r} + 8'd63;
    range_bad = (in_note_number < base_r) || ({1'b0, in_note_number} > base_top);
    ch_bad    = |in_channel[3:2];
    dur_q     = in_duration[15:4];
    dur_sat   = (|dur_q[11:6]) ? DUR_MAX : dur_q[5:0];

    if (!in_command && range_bad) begin
      status = ST_RANGE;
    end else if (!in_command && ch_bad) begin
      status = ST_CHANNEL;
    end else if (t < wh_r) begin
      status = ST_BACKWARD;
    end else if (d_ext > LONG_LIMIT) begin
      status = ST_TOO_LONG;
    end else begin
      status = ST_OK;
    end

    item             = '0;
    item.status      = status;
    item.coarse_byte = COARSE_TAG | 8'((rem >> 7) - REM_W'(1));
    fine_val         = '0;
    if (status != ST_OK) begin
      item.err = 1'b1;
    end else begin
      if (d_nz) begin
        item.n_long     = LONG_W'(dm1 >> LONG_STEP_SH);
        item.has_coarse = (rem > COARSE_MIN);
        fine_val        = item.has_coarse ? {1'b0, rem[6:0]} : rem[7:0];
      end
      item.has_fine   = (fine_val != 8'd0);
      item.fine_byte  = fine_val - 8'd1;
      item.has_note0  = !in_command;
      item.has_note1  = !in_command;
      item.note0_byte = {NOTE_TAG, 6'(in_note_number - base_r) & NOTE_SPAN};
      item.note1_byte = {in_channel[1:0], dur_sat};
    end

    accept    = in_valid && !q_full;
    push      = accept && item_pending(item);
    push_item = item;
    wh_nxt    = (accept && status == ST_OK) ? t : wh_r;
    base_nxt  = cfg_valid ? cfg_note_base : base_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wh_r   <= '0;
      base_r <= NOTE_BASE_RESET;
    end else begin
      wh_r   <= wh_nxt;
      base_r <= base_nxt;
    end
  end

endmodule

FILE: sv/sebe_queue.sv
// Short queue of classified transactions between the front and back ends.
// Register array with read and write pointers; depends on sebe_pkg.
module sebe_queue import sebe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  sebe_item_t push_item,
  input  logic       pop,
  output sebe_item_t head_item,
  output logic       full,
  output logic       empty
);

  sebe_item_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
    empty      = (cnt_r == '0);
    head_item  = mem_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: sv/sebe_back.sv
// Back end: emits the bytes of queued classified transactions, one per cycle while
// out_stall is low. Drives the registered output channel; depends on sebe_pkg.
module sebe_back import sebe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  sebe_item_t head_item,
  input  logic       q_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic [2:0] out_status
);

  sebe_item_t w_r, w_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       ol_r, ol_nxt;
  logic [2:0] os_r, os_nxt;
  logic       advance;

  always_comb begin
    advance = !ov_r || !out_stall;
    w_nxt   = w_r;
    ov_nxt  = ov_r;
    ob_nxt  = ob_r;
    ol_nxt  = ol_r;
    os_nxt  = os_r;
    pop     = 1'b0;
    if (!item_pending(w_r)) begin
      if (!q_empty) begin
        pop   = 1'b1;
        w_nxt = head_item;
      end
      if (advance) begin
        ov_nxt = 1'b0;
      end
    end else if (advance) begin
      ov_nxt = 1'b1;
      os_nxt = ST_OK;
      if (w_r.err) begin
        ob_nxt    = 8'd0;
        os_nxt    = w_r.status;
        w_nxt.err = 1'b0;
      end else if (w_r.n_long != '0) begin
        ob_nxt       = LONG_BYTE;
        w_nxt.n_long = w_r.n_long - LONG_W'(1);
      end else if (w_r.has_coarse) begin
        ob_nxt           = w_r.coarse_byte;
        w_nxt.has_coarse = 1'b0;
      end else if (w_r.has_fine) begin
        ob_nxt         = w_r.fine_byte;
        w_nxt.has_fine = 1'b0;
      end else if (w_r.has_note0) begin
        ob_nxt          = w_r.note0_byte;
        w_nxt.has_note0 = 1'b0;
      end else begin
        ob_nxt          = w_r.note1_byte;
        w_nxt.has_note1 = 1'b0;
      end
      ol_nxt = !item_pending(w_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r  <= '0;
      ov_r <= 1'b0;
    end else begin
      w_r  <= w_nxt;
      ov_r <= ov_nxt;
    end
    ob_r <= ob_nxt;
    ol_r <= ol_nxt;
    os_r <= os_nxt;
  end

  assign out_valid  = ov_r;
  assign out_byte   = ob_r;
  assign out_last   = ol_r;
  assign out_status = os_r;

  // An error result is always a single zero byte that closes its transaction.
  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && os_r != ST_OK) |-> (ol_r && ob_r == 8'd0))
    else $error("error result is not a lone zero byte");

  // Bytes of one transaction follow each other without a gap.
  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_stall && !ol_r) |=> ov_r)
    else $error("gap inside a transaction's byte sequence");

  // An error transaction carries no stream bytes besides its error result.
  assert property (@(posedge clk) disable iff (!rst_n)
    w_r.err |-> (w_r.n_long == '0 && !w_r.has_coarse && !w_r.has_fine &&
                 !w_r.has_note0 && !w_r.has_note1))
    else $error("error transaction also holds stream bytes");

  // A new transaction is taken only once the previous one is fully emitted.
  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !ol_r) |-> !pop)
    else $error("transaction loaded before the previous one finished");

endmodule

FILE: sv/song_event_byte_encoder.sv
// Top level of the song event byte encoder: front end, queue and back end.
// Depends on sebe_pkg, sebe_front, sebe_queue and sebe_back.
//
// Input transactions (note events or end of song) are taken on the in_ channel
// when in_valid is high and in_stall is low. The front end checks each one at
// once, moves the write head and places a classified entry in a two-entry queue;
// in_stall is high only while that queue is full. An end of song with no delay
// produces nothing.
// The back end loads each entry from the queue, then emits its bytes one per
// cycle on the out_ channel while out_stall is low, out_last marking the final
// byte of each transaction. The back end takes a new entry only after the
// previous transaction's last byte has been emitted.
// When out_stall is high the current result is held and the back end pauses;
// the front end keeps accepting until the queue fills.
// The note base register is written through cfg_valid/cfg_note_base; cfg_ready
// is always high. Reset (rst_n low, synchronous) clears the write head and the
// queue, drops any pending output and sets the note base to 39.
module song_event_byte_encoder import sebe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [23:0] in_event_time,
  input  logic [6:0]  in_note_number,
  input  logic [3:0]  in_channel,
  input  logic [15:0] in_duration,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [2:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_note_base
);

  sebe_item_t push_item;
  sebe_item_t head_item;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;

  sebe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_command     (in_command),
    .in_event_time  (in_event_time),
    .in_note_number (in_note_number),
    .in_channel     (in_channel),
    .in_duration    (in_duration),
    .cfg_valid      (cfg_valid),
    .cfg_note_base  (cfg_note_base),
    .q_full         (q_full),
    .push           (push),
    .push_item      (push_item)
  );

  sebe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  sebe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_item  (head_item),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .out_status (out_status)
  );

endmodule

FILE: verif/song_stream_board.sv
// Scoreboard for the song event byte encoder: predicts the byte stream from
// accepted input transactions and checks every result transaction in order.
// Depends on sebe_pkg for the status codes, byte constants and limits.
package song_stream_board_pkg;
  import sebe_pkg::*;

  localparam logic CMD_NOTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam int unsigned LONG_STEP = 1 << LONG_STEP_SH;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic [2:0] status;
  } stream_byte_t;

  class song_stream_board;
    logic [6:0]   note_base;
    logic [23:0]  write_head;
    stream_byte_t expected_q[$];
    int           errors;

    function new();
      note_base  = NOTE_BASE_RESET;
      write_head = '0;
      errors     = 0;
    endfunction

    function void note_input(logic cmd, logic [23:0] t, logic [6:0] note, logic [3:0] ch,
                             logic [15:0] dur);
      stream_byte_t bytes[$];
      stream_byte_t b;
      logic [2:0]   status;
      int unsigned  d;
      logic [5:0]   q;
      status = ST_OK;
      d      = 32'(t) - 32'(write_head);
      if (cmd == CMD_NOTE &&
          (note < note_base || int'(note) > int'(note_base) + int'(NOTE_SPAN)))
        status = ST_RANGE;
      else if (cmd == CMD_NOTE && ch > 4'd3)
        status = ST_CHANNEL;
      else if (t < write_head)
        status = ST_BACKWARD;
      else if (d > LONG_LIMIT)
        status = ST_TOO_LONG;
      if (status != ST_OK) begin
        b = '{8'h00, 1'b1, status};
        expected_q.push_back(b);
        return;
      end
      b.last   = 1'b0;
      b.status = ST_OK;
      while (d > LONG_STEP) begin
        b.data = LONG_BYTE;
        bytes.push_back(b);
        d -= LONG_STEP;
      end
      if (d > COARSE_MIN) begin
        b.data = COARSE_TAG | 8'((d >> 7) - 1);
        bytes.push_back(b);
        d &= 32'h7f;
      end
      if (d != 0) begin
        b.data = 8'(d - 1);
        bytes.push_back(b);
      end
      if (cmd == CMD_NOTE) begin
        q = ((dur >> 4) > 16'(DUR_MAX)) ? DUR_MAX : 6'(dur >> 4);
        b.data = {NOTE_TAG, 6'(note - note_base)};
        bytes.push_back(b);
        b.data = {ch[1:0], q};
        bytes.push_back(b);
      end
      write_head = t;
      if (bytes.size() > 0)
        bytes[bytes.size() - 1].last = 1'b1;
      foreach (bytes[i])
        expected_q.push_back(bytes[i]);
    endfunction

    function void check_result(logic [7:0] data, logic last, logic [2:0] status);
      stream_byte_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction: out_byte %0h, out_last %0b, out_status %0d",
               data, last, status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %0h, got %0h", want.data, data);
        errors++;
      end
      if (last !== want.last) begin
        $error("out_last: expected %0b, got %0b", want.last, last);
        errors++;
      end
      if (status !== want.status) begin
        $error("out_status: expected %0d, got %0d", want.status, status);
        errors++;
      end
    endfunction
  endclass

endpackage

FILE: verif/tb_top.sv
// Testbench top for song_event_byte_encoder: directed and random note and end-of-song
// transactions with bursty input pacing and patterned output stalls, checked in order.
// Depends on sebe_pkg, song_stream_board_pkg and the encoder RTL.
module tb_top;
  import sebe_pkg::*;
  import song_stream_board_pkg::*;

  localparam int unsigned TOP_TIME  = 32'hffffff;
  localparam int unsigned MAX_DELAY = (MAX_LONG_DELAYS + 1) * LONG_STEP;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CHUNK_ITEMS   = 13;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic        in_command     = 1'b0;
  logic [23:0] in_event_time  = '0;
  logic [6:0]  in_note_number = '0;
  logic [3:0]  in_channel     = '0;
  logic [15:0] in_duration    = '0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [2:0]  out_status;
  logic        cfg_valid      = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_note_base  = '0;

  song_stream_board board;
  int       burst_left  = 0;
  int       hold_asks   = 0;
  int       hold_served = 0;
  int       hold_left   = 0;
  int       rx_cycle    = 0;
  int       idle_cycles = 0;
  rx_mode_t rx_mode     = RX_FREE;

  song_event_byte_encoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_event_time  (in_event_time),
    .in_note_number (in_note_number),
    .in_channel     (in_channel),
    .in_duration    (in_duration),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_note_base  (cfg_note_base)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_byte, out_last, out_status);
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0)
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_served != hold_asks) begin
      hold_served <= hold_asks;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else begin
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
        default:  out_stall <= (rx_cycle % 8 < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send_item(logic cmd, logic [23:0] t, logic [6:0] note, logic [3:0] ch,
                           logic [15:0] dur);
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_event_time  <= t;
    in_note_number <= note;
    in_channel     <= ch;
    in_duration    <= dur;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_input(cmd, t, note, ch, dur);
    pace();
  endtask

  task automatic configure(logic [6:0] base);
    in_valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid     <= 1'b1;
    cfg_note_base <= base;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    board.note_base = base;
  endtask

  function automatic int unsigned pick_delay();
    case ($urandom_range(0, 9))
      0, 1, 2: return 0;
      3, 4, 5: return $urandom_range(1, 128);
      6, 7:    return $urandom_range(129, 8192);
      8:       return $urandom_range(8193, 40000);
      default: return $urandom_range(40001, MAX_DELAY);
    endcase
  endfunction

  function automatic logic [23:0] ahead(int unsigned d);
    int unsigned sum;
    sum = 32'(board.write_head) + d;
    return (sum > TOP_TIME) ? 24'(TOP_TIME) : 24'(sum);
  endfunction

  function automatic logic [6:0] pick_note();
    int top;
    top = int'(board.note_base) + int'(NOTE_SPAN);
    if (top > 127)
      top = 127;
    return 7'($urandom_range(int'(board.note_base), top));
  endfunction

  function automatic logic [15:0] pick_duration();
    return ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 1100)) : 16'($urandom);
  endfunction

  task automatic send_random_item();
    int unsigned pick;
    logic [23:0] t;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      send_item(CMD_NOTE, ahead(pick_delay()), pick_note(), 4'($urandom_range(0, 3)),
                pick_duration());
    end else if (pick < 78) begin
      send_item(CMD_END, ahead(pick_delay()), 7'($urandom), 4'($urandom), 16'($urandom));
    end else if (pick < 83) begin
      send_item(CMD_NOTE, ahead(pick_delay()), 7'($urandom), 4'($urandom_range(0, 3)),
                pick_duration());
    end else if (pick < 87) begin
      send_item(CMD_NOTE, ahead(pick_delay()), pick_note(), 4'($urandom_range(4, 15)),
                pick_duration());
    end else if (pick < 92) begin
      t = (board.write_head == '0) ? '0 :
          24'($urandom_range(0, 32'(board.write_head) - 1));
      send_item(1'($urandom), t, pick_note(), 4'($urandom_range(0, 3)), pick_duration());
    end else if (pick < 95) begin
      send_item(1'($urandom), ahead(MAX_DELAY + 1 + $urandom_range(0, 50000)), pick_note(),
                4'($urandom_range(0, 3)), pick_duration());
    end else begin
      send_item(1'($urandom), 24'($urandom), 7'($urandom), 4'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [6:0] bases[6];
    board = new();
    bases = '{7'd0, 7'd127, 7'd64, 7'($urandom), 7'($urandom), NOTE_BASE_RESET};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_item(CMD_NOTE, 24'd0, 7'd39, 4'd0, 16'd0);
    send_item(CMD_NOTE, 24'd0, 7'd102, 4'd3, 16'hffff);
    send_item(CMD_NOTE, 24'd0, 7'd103, 4'd0, 16'd100);
    send_item(CMD_NOTE, 24'd0, 7'd38, 4'd0, 16'd100);
    send_item(CMD_NOTE, 24'd0, 7'd127, 4'd15, 16'd100);
    send_item(CMD_NOTE, 24'd0, 7'd50, 4'd4, 16'd100);
    send_item(CMD_NOTE, 24'd0, 7'd50, 4'd15, 16'd100);
    send_item(CMD_NOTE, 24'd1, 7'd60, 4'd1, 16'd1007);
    send_item(CMD_NOTE, 24'd129, 7'd61, 4'd2, 16'd1008);
    send_item(CMD_NOTE, 24'd258, 7'd62, 4'd3, 16'd15);
    send_item(CMD_NOTE, 24'd8450, 7'd63, 4'd0, 16'd16);
    send_item(CMD_NOTE, 24'd16643, 7'd64, 4'd1, 16'd5000);
    send_item(CMD_END, 24'd16643, 7'd0, 4'd0, 16'd0);
    send_item(CMD_END, 24'd16943, 7'd127, 4'd15, 16'hffff);
    send_item(CMD_NOTE, 24'd16942, 7'd70, 4'd0, 16'd200);
    send_item(CMD_END, 24'd0, 7'd0, 4'd15, 16'd0);
    send_item(CMD_NOTE, 24'(16943 + MAX_DELAY + 1), 7'd70, 4'd1, 16'd200);
    send_item(CMD_END, 24'(16943 + MAX_DELAY + 1), 7'd0, 4'd0, 16'd0);
    send_item(CMD_NOTE, 24'(16943 + MAX_DELAY - 1), 7'd40, 4'd2, 16'd500);
    send_item(CMD_END, 24'(16943 + 2 * MAX_DELAY - 1), 7'd0, 4'd0, 16'd0);
    send_item(CMD_NOTE, 24'(16943 + 2 * MAX_DELAY - 1), 7'd39, 4'd0, 16'd0);

    foreach (bases[i]) begin
      configure(bases[i]);
      if (i == 2) begin
        hold_asks++;
        burst_left = 3 * CHUNK_ITEMS;
      end
      repeat (CHUNK_ITEMS) send_random_item();
    end

    while (TOP_TIME - 32'(board.write_head) > MAX_DELAY)
      send_item(CMD_END, 24'(32'(board.write_head) + MAX_DELAY), 7'($urandom), 4'($urandom),
                16'($urandom));
    send_item(CMD_NOTE, 24'(TOP_TIME), pick_note(), 4'd3, 16'hffff);
    send_item(CMD_END, 24'(TOP_TIME), 7'($urandom), 4'($urandom), 16'($urandom));
    send_item(CMD_NOTE, 24'(TOP_TIME - 1), pick_note(), 4'd0, 16'd0);

    in_valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
sv/sebe_pkg.sv
sv/sebe_front.sv
sv/sebe_queue.sv
sv/sebe_back.sv
sv/song_event_byte_encoder.sv
verif/song_stream_board.sv
verif/tb_top.sv
